// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/mncf_pkg.sv
// ----------------------------------------------------------------------------
// mncf_pkg
// Shared codes, sizes and types of the motor node command framer.
// ----------------------------------------------------------------------------
package mncf_pkg;

	// Command codes that produce a frame.
	localparam logic [3:0] CODE_CLEAR_FAULT = 4'd1;
	localparam logic [3:0] CODE_SPEED       = 4'd3;
	localparam logic [3:0] CODE_REG_READ    = 4'd5;
	localparam logic [3:0] CODE_REG_WRITE   = 4'd6;
	localparam logic [3:0] CODE_QUAD_FIRST  = 4'd8;
	localparam logic [3:0] CODE_QUAD_LAST   = 4'd11;

	// Fixed payload of the clear-fault frame.
	localparam logic [15:0] CLEAR_FAULT_WORD = 16'hff01;

	// Frame geometry: up to five data words plus the checksum word.
	localparam int FRAME_WORDS = 6;
	localparam int DATA_WORDS  = 5;
	localparam logic [3:0] LAST_IDX_SHORT = 4'd7;
	localparam logic [3:0] LAST_IDX_LONG  = 4'd11;

	// Default depth of the queue between front and back.
	localparam int QUEUE_DEPTH_DEF = 2;

	typedef logic [15:0] word_t;

	// One complete frame ready for serialization.
	typedef struct packed {
		logic                         long_frame;
		logic [FRAME_WORDS-1:0][15:0] words;
	} frame_t;

	// Queue status seen by the front and back parts.
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

// File: src/mncf_front.sv
// ----------------------------------------------------------------------------
// mncf_front
// Accepts requests, drops codes without a frame, lays out the payload words
// and appends the checksum before handing the frame to the queue.
// ----------------------------------------------------------------------------
module mncf_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic [3:0]          req_type,
	input  logic [7:0]          target_node,
	input  logic [15:0]         register_address,
	input  logic [15:0]         register_value,
	input  logic [15:0]         speed_0,
	input  logic [15:0]         speed_1,
	input  logic [15:0]         speed_2,
	input  logic [15:0]         speed_3,
	input  mncf_pkg::q_status_t q_status,
	output logic                q_push,
	output mncf_pkg::frame_t    q_frame
);
	import mncf_pkg::*;

	logic                        known;
	logic                        long_dec;
	logic [DATA_WORDS-1:0][15:0] data_dec;
	logic                        accept;

	logic                        valid_s1;
	logic                        long_s1;
	logic [DATA_WORDS-1:0][15:0] data_s1;

	word_t                       sum;
	word_t                       ck;

	// Classify the request and place its fields into big-endian words.
	always_comb begin
		known    = 1'b1;
		long_dec = 1'b0;
		data_dec = '0;
		data_dec[0] = {target_node, 4'b0000, req_type};
		case (req_type) inside
			CODE_CLEAR_FAULT: begin
				data_dec[1] = CLEAR_FAULT_WORD;
			end
			CODE_SPEED: begin
				data_dec[2] = speed_0;
			end
			CODE_REG_READ: begin
				data_dec[1] = register_address;
			end
			CODE_REG_WRITE: begin
				data_dec[1] = register_address;
				data_dec[2] = register_value;
			end
			[CODE_QUAD_FIRST:CODE_QUAD_LAST]: begin
				long_dec    = 1'b1;
				data_dec[1] = speed_0;
				data_dec[2] = speed_1;
				data_dec[3] = speed_2;
				data_dec[4] = speed_3;
			end
			default: begin
				known = 1'b0;
			end
		endcase
	end

	// A word is taken whenever the stage is free or drains into the queue.
	assign full   = valid_s1 && q_status.full;
	assign accept = push && !full;
	assign q_push = valid_s1 && !q_status.full;

	// Stage register; requests without a frame are taken and dropped here.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= known;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			long_s1 <= long_dec;
			data_s1 <= data_dec;
		end
	end

	// Checksum is the negated 16-bit sum of the data words.
	always_comb begin
		sum = '0;
		for (int i = 0; i < DATA_WORDS; i++) begin
			sum = sum + data_s1[i];
		end
		ck = 16'd0 - sum;
	end

	// Short frames carry the checksum in the fourth word, long ones in the sixth.
	always_comb begin
		q_frame.long_frame = long_s1;
		q_frame.words      = '0;
		if (long_s1) begin
			for (int i = 0; i < DATA_WORDS; i++) begin
				q_frame.words[i] = data_s1[i];
			end
			q_frame.words[5] = ck;
		end else begin
			for (int i = 0; i < 3; i++) begin
				q_frame.words[i] = data_s1[i];
			end
			q_frame.words[3] = ck;
		end
	end

endmodule

// File: src/mncf_queue.sv
// ----------------------------------------------------------------------------
// mncf_queue
// Short shift queue of complete frames between the front and back parts.
// ----------------------------------------------------------------------------
module mncf_queue #(
	parameter int DEPTH = mncf_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_push,
	input  mncf_pkg::frame_t    q_frame,
	input  logic                q_pop,
	output mncf_pkg::frame_t    q_head,
	output mncf_pkg::q_status_t q_status
);
	import mncf_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);

	frame_t          slot_q [DEPTH];
	logic   [CW-1:0] count_q;
	logic            push_en;
	logic            pop_en;
	logic   [CW-1:0] wr_idx;

	assign q_status.full  = (count_q == CW'(DEPTH));
	assign q_status.empty = (count_q == '0);
	assign push_en = q_push && !q_status.full;
	assign pop_en  = q_pop && !q_status.empty;
	assign wr_idx  = count_q - {{(CW-1){1'b0}}, pop_en};
	assign q_head  = slot_q[0];

	// Occupancy count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_q + {{(CW-1){1'b0}}, push_en} - {{(CW-1){1'b0}}, pop_en};
		end
	end

	// Each slot shifts toward the head on a pop and takes new words at the tail.
	for (genvar i = 0; i < DEPTH; i++) begin : g_slot
		always_ff @(posedge clk) begin
			if (push_en && (wr_idx == CW'(i))) begin
				slot_q[i] <= q_frame;
			end else if (pop_en) begin
				if (i < DEPTH - 1) begin
					slot_q[i] <= slot_q[(i < DEPTH - 1) ? i + 1 : i];
				end
			end
		end
	end

endmodule

// File: src/mncf_back.sv
// ----------------------------------------------------------------------------
// mncf_back
// Serializes the frame at the queue head into bytes held in an output register.
// ----------------------------------------------------------------------------
module mncf_back (
	input  logic                clk,
	input  logic                arst_n,
	input  mncf_pkg::frame_t    q_head,
	input  mncf_pkg::q_status_t q_status,
	output logic                q_pop,
	output logic                empty,
	input  logic                pop,
	output logic [7:0]          frame_byte,
	output logic [3:0]          byte_index,
	output logic                last_byte
);
	import mncf_pkg::*;

	logic [3:0] idx_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic [3:0] out_idx_q;
	logic       out_last_q;

	logic       adv;
	logic       load;
	logic       is_last;
	word_t      cur_word;
	logic [7:0] cur_byte;

	assign adv     = !out_valid_q || pop;
	assign load    = adv && !q_status.empty;
	assign is_last = (idx_q == (q_head.long_frame ? LAST_IDX_LONG : LAST_IDX_SHORT));
	assign q_pop   = load && is_last;

	// Pick the word holding the current byte, high byte first.
	always_comb begin
		case (idx_q[3:1])
			3'd0:    cur_word = q_head.words[0];
			3'd1:    cur_word = q_head.words[1];
			3'd2:    cur_word = q_head.words[2];
			3'd3:    cur_word = q_head.words[3];
			3'd4:    cur_word = q_head.words[4];
			3'd5:    cur_word = q_head.words[5];
			default: cur_word = '0;
		endcase
		cur_byte = idx_q[0] ? cur_word[7:0] : cur_word[15:8];
	end

	// Byte counter within the head frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (load) begin
			idx_q <= is_last ? 4'd0 : idx_q + 4'd1;
		end
	end

	// Output register; refilled whenever it is empty or being taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= !q_status.empty;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= cur_byte;
			out_idx_q  <= idx_q;
			out_last_q <= is_last;
		end
	end

	assign empty      = !out_valid_q;
	assign frame_byte = out_byte_q;
	assign byte_index = out_idx_q;
	assign last_byte  = out_last_q;

endmodule

// File: src/motor_node_command_framer.sv
// ----------------------------------------------------------------------------
// motor_node_command_framer
// Turns motor node command requests into checksummed serial frames.
// ----------------------------------------------------------------------------
// Each accepted request leaves as 8 bytes (clear fault, speed, register read
// and write) or 12 bytes (four-speed codes 8 to 11), one byte per cycle while
// the receiver pops, with its position in byte_index and last_byte set on the
// checksum low byte. Other codes are accepted and produce no words. The byte
// serializer sets the frame rate. Requests are taken one per cycle until the
// front stage and the frame queue (QUEUE_DEPTH frames) are occupied; with
// nothing ahead of it, a request passes through the front stage register, the
// frame queue and the serializer's output register before its first byte.
module motor_node_command_framer #(
	parameter int QUEUE_DEPTH = mncf_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [3:0]  req_type,
	input  logic [7:0]  target_node,
	input  logic [15:0] register_address,
	input  logic [15:0] register_value,
	input  logic [15:0] speed_0,
	input  logic [15:0] speed_1,
	input  logic [15:0] speed_2,
	input  logic [15:0] speed_3,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  frame_byte,
	output logic [3:0]  byte_index,
	output logic        last_byte
);
	import mncf_pkg::*;

	q_status_t q_status;
	logic      q_push;
	logic      q_pop;
	frame_t    q_frame;
	frame_t    q_head;

	// Request decode and checksum.
	mncf_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.push             (push),
		.full             (full),
		.req_type         (req_type),
		.target_node      (target_node),
		.register_address (register_address),
		.register_value   (register_value),
		.speed_0          (speed_0),
		.speed_1          (speed_1),
		.speed_2          (speed_2),
		.speed_3          (speed_3),
		.q_status         (q_status),
		.q_push           (q_push),
		.q_frame          (q_frame)
	);

	// Frame queue.
	mncf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_push   (q_push),
		.q_frame  (q_frame),
		.q_pop    (q_pop),
		.q_head   (q_head),
		.q_status (q_status)
	);

	// Byte serializer.
	mncf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_head     (q_head),
		.q_status   (q_status),
		.q_pop      (q_pop),
		.empty      (empty),
		.pop        (pop),
		.frame_byte (frame_byte),
		.byte_index (byte_index),
		.last_byte  (last_byte)
	);

endmodule

// File: src/mncf_checker.sv
// ----------------------------------------------------------------------------
// mncf_checker
// Port-level checks of frame sequencing on the framer's result side.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mncf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       empty,
	input logic       pop,
	input logic [7:0] frame_byte,
	input logic [3:0] byte_index,
	input logic       last_byte
);

	// The end of a frame falls only on the last byte of a short or long frame.
	`ASSERT_SAME(a_last_pos, clk, arst_n, !empty && last_byte, byte_index == 4'd7 || byte_index == 4'd11, "last byte at a wrong position")

	// Inside a frame the next byte follows at once with the next position.
	`ASSERT_NEXT(a_inframe, clk, arst_n, pop && !empty && !last_byte, !empty && byte_index == $past(byte_index) + 4'd1, "frame interrupted or out of order")

	// After a frame ends, any following word starts a new frame.
	`ASSERT_NEXT(a_new_frame, clk, arst_n, pop && !empty && last_byte, empty || byte_index == 4'd0, "frame started at a nonzero position")

	// A waiting word holds until it is taken.
	`ASSERT_NEXT(a_hold, clk, arst_n, !empty && !pop, !empty && $stable(frame_byte) && $stable(byte_index), "waiting word changed")

endmodule

bind motor_node_command_framer mncf_checker u_mncf_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.empty      (empty),
	.pop        (pop),
	.frame_byte (frame_byte),
	.byte_index (byte_index),
	.last_byte  (last_byte)
);

// File: bench/motor_node_command_framer_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// motor_node_command_framer_tb
// Self-checking bench for the motor node command framer.
// ---------------------------------------------------------------------------
// Requests go in through the push/full side and frame bytes come out through
// the pop/empty side. Every byte, its index and its end-of-frame flag are
// compared with hand-typed frames or a local model of the framing and
// checksum rules. A directed table covers every command code and the field
// extremes. Random requests follow, with random idle cycles on both sides, a
// long receiver hold-off that backs the block up, and full drains in between.
// ---------------------------------------------------------------------------
module motor_node_command_framer_tb;
	import mncf_pkg::*;

	localparam int CLK_HIGH_NS  = 6;
	localparam int CLK_LOW_NS   = 6;
	localparam int RESET_CYCLES = 9;
	localparam int HOLD_CYCLES  = 300;
	localparam int END_CYCLES   = 24;
	localparam int MAX_REPORTS  = 10;
	localparam int IDLE_PCT     = 7;
	localparam int NO_GOLD      = -1;
	localparam int MAX_FRAME    = 12;
	localparam longint LIMIT_NS = 2_000_000;

	// One command request as seen on the input ports.
	typedef struct packed {
		logic [3:0]       code;
		logic [7:0]       node;
		word_t            raddr;
		word_t            rval;
		logic [3:0][15:0] spd;
	} cmd_t;

	// One frame byte as seen on the output ports.
	typedef struct packed {
		logic [7:0] data;
		logic [3:0] idx;
		logic       last;
	} frame_byte_t;

	// A directed row; gold holds the frame right-justified, first byte highest.
	typedef struct {
		cmd_t        cmd;
		int          gold_len;
		logic [95:0] gold;
	} stim_row_t;

	logic        clk    = 1'b0;
	logic        arst_n = 1'b0;
	logic        push   = 1'b0;
	logic        pop    = 1'b0;
	logic        full;
	logic        empty;
	logic [7:0]  frame_byte;
	logic [3:0]  byte_index;
	logic        last_byte;

	cmd_t        item_cmd      = '0;
	int          item_gold_len = NO_GOLD;
	logic [95:0] item_gold     = '0;

	frame_byte_t expected_bytes[$];
	stim_row_t   directed_rows[$];
	int          fail_count  = 0;
	int          tx_idle_pct = IDLE_PCT;
	int          rx_idle_pct = IDLE_PCT;
	int          hold_kicks  = 0;
	int          hold_served = 0;
	int          hold_left   = 0;

	motor_node_command_framer DUT (
		.clk              (clk),
		.arst_n           (arst_n),
		.push             (push),
		.full             (full),
		.req_type         (item_cmd.code),
		.target_node      (item_cmd.node),
		.register_address (item_cmd.raddr),
		.register_value   (item_cmd.rval),
		.speed_0          (item_cmd.spd[0]),
		.speed_1          (item_cmd.spd[1]),
		.speed_2          (item_cmd.spd[2]),
		.speed_3          (item_cmd.spd[3]),
		.empty            (empty),
		.pop              (pop),
		.frame_byte       (frame_byte),
		.byte_index       (byte_index),
		.last_byte        (last_byte)
	);

	// Free-running clock.
	always begin
		#(CLK_HIGH_NS) clk = 1'b1;
		#(CLK_LOW_NS) clk = 1'b0;
	end

	// Counts a failure and reports only the first few of them.
	task automatic report_failure(input string msg);
		fail_count++;
		if (fail_count <= MAX_REPORTS) begin
			$display("%s", msg);
		end
	endtask

	// Builds the frame of one request and queues its bytes as expected words.
	task automatic predict_frame(input cmd_t c);
		logic [7:0]  fb [0:MAX_FRAME-1];
		logic [15:0] sum;
		logic [15:0] ck;
		int          len;
		frame_byte_t nb;
		for (int i = 0; i < MAX_FRAME; i++) begin
			fb[i] = 8'h00;
		end
		fb[0] = c.node;
		fb[1] = {4'h0, c.code};
		len = 8;
		case (c.code)
			CODE_CLEAR_FAULT: {fb[2], fb[3]} = CLEAR_FAULT_WORD;
			CODE_SPEED:       {fb[4], fb[5]} = c.spd[0];
			CODE_REG_READ:    {fb[2], fb[3]} = c.raddr;
			CODE_REG_WRITE: begin
				{fb[2], fb[3]} = c.raddr;
				{fb[4], fb[5]} = c.rval;
			end
			default: begin
				if (c.code >= CODE_QUAD_FIRST && c.code <= CODE_QUAD_LAST) begin
					for (int w = 0; w < 4; w++) begin
						{fb[2 + 2 * w], fb[3 + 2 * w]} = c.spd[w];
					end
					len = 12;
				end else begin
					len = 0;
				end
			end
		endcase
		if (len != 0) begin
			// Checksum is the negated 16-bit sum of the big-endian byte pairs.
			sum = 16'h0000;
			for (int i = 0; i + 2 < len; i += 2) begin
				sum = sum + {fb[i], fb[i + 1]};
			end
			ck = 16'h0000 - sum;
			{fb[len - 2], fb[len - 1]} = ck;
			for (int i = 0; i < len; i++) begin
				nb.data = fb[i];
				nb.idx  = 4'(i);
				nb.last = (i == len - 1);
				expected_bytes.push_back(nb);
			end
		end
	endtask

	// Random word with the extremes drawn more often.
	function automatic word_t rand_word();
		int pick;
		pick = $urandom_range(9);
		if (pick == 0) begin
			return 16'h0000;
		end else if (pick == 1) begin
			return 16'hffff;
		end
		return 16'($urandom_range(65535));
	endfunction

	// Random request, mostly codes that produce a frame.
	function automatic cmd_t random_cmd();
		cmd_t c;
		int   sel;
		if ($urandom_range(99) < 88) begin
			sel = $urandom_range(7);
			case (sel)
				0: c.code = CODE_CLEAR_FAULT;
				1: c.code = CODE_SPEED;
				2: c.code = CODE_REG_READ;
				3: c.code = CODE_REG_WRITE;
				default: c.code = CODE_QUAD_FIRST + 4'(sel - 4);
			endcase
		end else begin
			c.code = 4'($urandom_range(15));
		end
		c.node  = 8'(rand_word());
		c.raddr = rand_word();
		c.rval  = rand_word();
		for (int w = 0; w < 4; w++) begin
			c.spd[w] = rand_word();
		end
		return c;
	endfunction

	// Appends one row to the directed table.
	task automatic add_row(input logic [3:0] code, input logic [7:0] node,
			input word_t raddr, input word_t rval, input word_t s0, input word_t s1,
			input word_t s2, input word_t s3, input int gold_len, input logic [95:0] gold);
		stim_row_t row;
		row.cmd.code   = code;
		row.cmd.node   = node;
		row.cmd.raddr  = raddr;
		row.cmd.rval   = rval;
		row.cmd.spd[0] = s0;
		row.cmd.spd[1] = s1;
		row.cmd.spd[2] = s2;
		row.cmd.spd[3] = s3;
		row.gold_len   = gold_len;
		row.gold       = gold;
		directed_rows.push_back(row);
	endtask

	// Offers one request word and returns at the edge that accepts it.
	task automatic send_request(input cmd_t c, input int gold_len, input logic [95:0] gold);
		while ($urandom_range(99) < tx_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push          <= 1'b1;
		item_cmd      <= c;
		item_gold_len <= gold_len;
		item_gold     <= gold;
		@(posedge clk);
		while (full) begin
			@(posedge clk);
		end
	endtask

	task automatic run_random(input int count);
		for (int n = 0; n < count; n++) begin
			send_request(random_cmd(), NO_GOLD, '0);
		end
	endtask

	// Stops offering and waits until every expected byte has come out.
	task automatic pause_and_drain();
		push <= 1'b0;
		do begin
			@(posedge clk);
		end while (expected_bytes.size() != 0);
	endtask

	// Receiver: random pops, plus a long hold-off whenever one is requested.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			pop       <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_kicks != hold_served) begin
			hold_served <= hold_served + 1;
			hold_left   <= HOLD_CYCLES;
			pop         <= 1'b0;
		end else begin
			pop <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// Compares each output word with the oldest expectation, then records
	// the expectations of a request word accepted at the same edge.
	always @(posedge clk) begin : byte_checker
		frame_byte_t want;
		if (arst_n) begin
			if (pop && !empty) begin
				if (expected_bytes.size() == 0) begin
					report_failure($sformatf("unexpected byte %h index %0d last %b",
						frame_byte, byte_index, last_byte));
				end else begin
					want = expected_bytes.pop_front();
					if (frame_byte !== want.data || byte_index !== want.idx ||
							last_byte !== want.last) begin
						report_failure($sformatf(
							"mismatch: expected byte %h index %0d last %b, got byte %h index %0d last %b",
							want.data, want.idx, want.last, frame_byte, byte_index, last_byte));
					end
				end
			end
			if (push && !full) begin
				if (item_gold_len == NO_GOLD) begin
					predict_frame(item_cmd);
				end else begin
					for (int i = 0; i < item_gold_len; i++) begin
						want.data = item_gold[(item_gold_len - 1 - i) * 8 +: 8];
						want.idx  = 4'(i);
						want.last = (i == item_gold_len - 1);
						expected_bytes.push_back(want);
					end
				end
			end
		end
	end

	// Stimulus sequence.
	initial begin
		// Frames at the field extremes, typed in by hand.
		add_row(CODE_CLEAR_FAULT, 8'h00, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
			16'h0000, 16'h0000, 8, 64'h0001ff01000000fe);
		add_row(CODE_CLEAR_FAULT, 8'hff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
			16'hffff, 16'hffff, 8, 64'hff01ff01000001fe);
		add_row(CODE_SPEED, 8'h00, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
			16'h0000, 16'h0000, 8, 64'h000300000000fffd);
		add_row(CODE_SPEED, 8'hff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
			16'hffff, 16'hffff, 8, 64'hff030000ffff00fe);
		// Sum wraps to zero, so the checksum is zero too.
		add_row(CODE_SPEED, 8'h00, 16'h0000, 16'h0000, 16'hfffd, 16'h0000,
			16'h0000, 16'h0000, 8, 64'h00030000fffd0000);
		add_row(CODE_REG_READ, 8'h00, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
			16'h0000, 16'h0000, 8, 64'h000500000000fffb);
		add_row(CODE_REG_READ, 8'hff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
			16'hffff, 16'hffff, 8, 64'hff05ffff000000fc);
		add_row(CODE_REG_WRITE, 8'h00, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
			16'h0000, 16'h0000, 8, 64'h000600000000fffa);
		add_row(CODE_REG_WRITE, 8'hff, 16'hffff, 16'hffff, 16'h0000, 16'h0000,
			16'h0000, 16'h0000, 8, 64'hff06ffffffff00fc);
		add_row(CODE_QUAD_FIRST, 8'h00, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
			16'h0000, 16'h0000, 12, 96'h00080000000000000000fff8);
		add_row(CODE_QUAD_LAST, 8'hff, 16'h0000, 16'h0000, 16'hffff, 16'hffff,
			16'hffff, 16'hffff, 12, 96'hff0bffffffffffffffff00f9);
		// Every code without a frame must be accepted and emit nothing.
		for (int c = 0; c < 16; c++) begin
			if (!(c == CODE_CLEAR_FAULT || c == CODE_SPEED || c == CODE_REG_READ ||
					c == CODE_REG_WRITE || (c >= CODE_QUAD_FIRST && c <= CODE_QUAD_LAST))) begin
				add_row(4'(c), 8'(rand_word()), rand_word(), rand_word(), rand_word(),
					rand_word(), rand_word(), rand_word(), 0, '0);
			end
		end
		// Random contents checked against the model, ignored fields included.
		add_row(CODE_CLEAR_FAULT, 8'(rand_word()), rand_word(), rand_word(), rand_word(),
			rand_word(), rand_word(), rand_word(), NO_GOLD, '0);
		add_row(CODE_SPEED, 8'(rand_word()), rand_word(), rand_word(), rand_word(),
			rand_word(), rand_word(), rand_word(), NO_GOLD, '0);
		add_row(CODE_REG_READ, 8'(rand_word()), rand_word(), rand_word(), rand_word(),
			rand_word(), rand_word(), rand_word(), NO_GOLD, '0);
		add_row(CODE_REG_WRITE, 8'(rand_word()), rand_word(), rand_word(), rand_word(),
			rand_word(), rand_word(), rand_word(), NO_GOLD, '0);
		add_row(CODE_QUAD_FIRST + 4'd1, 8'(rand_word()), rand_word(), rand_word(),
			rand_word(), rand_word(), rand_word(), rand_word(), NO_GOLD, '0);
		add_row(CODE_QUAD_LAST - 4'd1, 8'(rand_word()), rand_word(), rand_word(),
			rand_word(), rand_word(), rand_word(), rand_word(), NO_GOLD, '0);

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			send_request(directed_rows[i].cmd, directed_rows[i].gold_len,
				directed_rows[i].gold);
		end

		// Random traffic with idle cycles on both sides.
		run_random(130);

		// No idling at all; the receiver first holds off so the block backs up.
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		hold_kicks  = hold_kicks + 1;
		run_random(130);
		pause_and_drain();

		tx_idle_pct = IDLE_PCT;
		rx_idle_pct = IDLE_PCT;
		run_random(120);
		pause_and_drain();
		repeat (END_CYCLES) @(posedge clk);

		if (expected_bytes.size() != 0) begin
			report_failure($sformatf("%0d expected bytes never arrived",
				expected_bytes.size()));
		end
		if (fail_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#(LIMIT_NS);
		$display("*** FAILED ***");
		$finish;
	end

endmodule

// File: motor_node_command_framer.f
+incdir+src
src/mncf_pkg.sv
src/mncf_front.sv
src/mncf_queue.sv
src/mncf_back.sv
src/motor_node_command_framer.sv
src/mncf_checker.sv
bench/motor_node_command_framer_tb.sv
